@@ hw/rtl/fbe_pkg.sv @@
package fbe_pkg;

    localparam int CRC_W       = 24;
    localparam int HCRC_W      = 11;
    localparam int SYM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CRC_W-1:0]  FRAME_CRC_SEED_RST = 24'hFEDCBA;
    localparam logic [CRC_W-1:0]  FRAME_POLY         = 24'h5D6DCB;
    localparam logic [HCRC_W-1:0] HDR_POLY           = 11'h385;
    localparam logic [HCRC_W-1:0] HDR_INIT           = 11'h01A;

    // Wire patterns: TSS+FSS is eight zeros then a one, FES+idle is a zero then eleven ones.
    localparam logic [SYM_W-1:0] SYM_TSS = 12'h001;
    localparam logic [SYM_W-1:0] SYM_FES = 12'h7FF;
    localparam logic [1:0]       SYM_BSS = 2'b10;
    localparam logic [CNT_W-1:0] BITS_TSS  = 4'd9;
    localparam logic [CNT_W-1:0] BITS_BYTE = 4'd10;
    localparam logic [CNT_W-1:0] BITS_FES  = 4'd12;

    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_PAYLOAD = 1'b1;

    typedef enum logic [1:0] {
        K_TSS,
        K_BYTE,
        K_FES
    } grp_kind_t;

    typedef struct packed {
        grp_kind_t  kind;
        logic [7:0] data;
        logic       last;
    } grp_t;

    typedef struct packed {
        logic valid;
        grp_t grp;
    } push_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HCRC,
        F_HDR,
        F_TRL
    } front_state_t;

    function automatic logic [CRC_W-1:0] frame_crc_byte(input logic [CRC_W-1:0] crc_in,
                                                        input logic [7:0] b);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = crc_in;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[CRC_W-1] ^ b[i];
            c  = {c[CRC_W-2:0], 1'b0};
            if (fb)
            begin
                c = c ^ FRAME_POLY;
            end
        end
        return c;
    endfunction

    function automatic logic [HCRC_W-1:0] hdr_crc_chunk(input logic [HCRC_W-1:0] crc_in,
                                                        input logic [4:0] bits);
        logic [HCRC_W-1:0] c;
        logic              fb;
        c = crc_in;
        for (int i = 4; i >= 0; i--)
        begin
            fb = c[HCRC_W-1] ^ bits[i];
            c  = {c[HCRC_W-2:0], 1'b0};
            if (fb)
            begin
                c = c ^ HDR_POLY;
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/fbe_item_if.sv @@
interface fbe_item_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [10:0] fid;
    logic [4:0]  indicators;
    logic [6:0]  payload_words;
    logic [5:0]  cycle_no;
    logic [7:0]  data_byte;

    modport source (
        output valid, func, fid, indicators, payload_words, cycle_no, data_byte,
        input  ready
    );
    modport sink (
        input  valid, func, fid, indicators, payload_words, cycle_no, data_byte,
        output ready
    );
endinterface

@@ hw/rtl/fbe_group_if.sv @@
interface fbe_group_if;
    import fbe_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol_bits;
    logic [CNT_W-1:0] bit_count;
    logic             last;

    modport source (
        output valid, symbol_bits, bit_count, last,
        input  ready
    );
    modport sink (
        input  valid, symbol_bits, bit_count, last,
        output ready
    );
endinterface

@@ hw/rtl/fbe_front.sv @@
module fbe_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [fbe_pkg::CRC_W-1:0]  cfg_wdata,
    fbe_item_if.sink                   frame_items,
    input  logic                       q_full,
    output fbe_pkg::push_t             push
);
    import fbe_pkg::*;

    localparam logic [2:0] HCRC_LAST = 3'd3;
    localparam logic [2:0] HDR_LAST  = 3'd4;
    localparam logic [2:0] TRL_LAST  = 3'd3;

    front_state_t      state_reg, state_next;
    logic [2:0]        step_reg, step_next;
    logic              in_frame_reg, in_frame_next;
    logic [7:0]        bytes_left_reg, bytes_left_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [CRC_W-1:0]  seed_reg;
    logic [HCRC_W-1:0] hcrc_reg, hcrc_next;
    logic [19:0]       hbits_reg, hbits_next;
    logic [10:0]       id_reg;
    logic [4:0]        ind_reg;
    logic [6:0]        words_reg;
    logic [5:0]        cyc_reg;

    logic       accept;
    logic       start_acc;
    logic       byte_acc;
    logic [7:0] hdr_byte;
    logic [7:0] trl_byte;
    logic [7:0] crc_data;
    logic [CRC_W-1:0] crc_upd;

    assign frame_items.ready = (state_reg == F_IDLE) && !q_full;
    assign accept    = frame_items.valid && frame_items.ready;
    assign start_acc = accept && (frame_items.func == FUNC_START);
    assign byte_acc  = accept && (frame_items.func == FUNC_PAYLOAD) && in_frame_reg;

    always_comb
    begin
        unique case (step_reg)
            3'd0:    hdr_byte = {ind_reg, id_reg[10:8]};
            3'd1:    hdr_byte = id_reg[7:0];
            3'd2:    hdr_byte = {words_reg, hcrc_reg[10]};
            3'd3:    hdr_byte = hcrc_reg[9:2];
            3'd4:    hdr_byte = {hcrc_reg[1:0], cyc_reg};
            default: hdr_byte = '0;
        endcase
    end

    always_comb
    begin
        unique case (step_reg)
            3'd0:    trl_byte = crc_reg[23:16];
            3'd1:    trl_byte = crc_reg[15:8];
            default: trl_byte = crc_reg[7:0];
        endcase
    end

    // One frame CRC unit serves both header bytes and payload bytes.
    assign crc_data = (state_reg == F_IDLE) ? frame_items.data_byte : hdr_byte;
    assign crc_upd  = frame_crc_byte(crc_reg, crc_data);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (start_acc)
                begin
                    state_next = F_HCRC;
                    step_next  = '0;
                end
                else if (byte_acc && (bytes_left_reg == 8'd1))
                begin
                    state_next = F_TRL;
                    step_next  = '0;
                end
            end
            F_HCRC:
            begin
                if (step_reg == HCRC_LAST)
                begin
                    state_next = F_HDR;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            F_HDR:
            begin
                if (!q_full)
                begin
                    if (step_reg == HDR_LAST)
                    begin
                        state_next = (words_reg == '0) ? F_TRL : F_IDLE;
                        step_next  = '0;
                    end
                    else
                    begin
                        step_next = step_reg + 3'd1;
                    end
                end
            end
            F_TRL:
            begin
                if (!q_full)
                begin
                    if (step_reg == TRL_LAST)
                    begin
                        state_next = F_IDLE;
                        step_next  = '0;
                    end
                    else
                    begin
                        step_next = step_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
                step_next  = '0;
            end
        endcase
    end

    // Queue pushes
    always_comb
    begin
        push.valid     = 1'b0;
        push.grp.kind  = K_BYTE;
        push.grp.data  = '0;
        push.grp.last  = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (start_acc)
                begin
                    push.valid    = 1'b1;
                    push.grp.kind = K_TSS;
                end
                else if (byte_acc)
                begin
                    push.valid    = 1'b1;
                    push.grp.data = frame_items.data_byte;
                    push.grp.last = (bytes_left_reg != 8'd1);
                end
            end
            F_HCRC:
            begin
                push.valid = 1'b0;
            end
            F_HDR:
            begin
                push.valid    = !q_full;
                push.grp.data = hdr_byte;
                push.grp.last = (step_reg == HDR_LAST) && (words_reg != '0);
            end
            F_TRL:
            begin
                push.valid = !q_full;
                if (step_reg == TRL_LAST)
                begin
                    push.grp.kind = K_FES;
                    push.grp.last = 1'b1;
                end
                else
                begin
                    push.grp.data = trl_byte;
                end
            end
            default:
            begin
                push.valid = 1'b0;
            end
        endcase
    end

    // Frame bookkeeping
    always_comb
    begin
        in_frame_next   = in_frame_reg;
        bytes_left_next = bytes_left_reg;
        crc_next        = crc_reg;
        hcrc_next       = hcrc_reg;
        hbits_next      = hbits_reg;
        if (start_acc)
        begin
            in_frame_next   = 1'b0;
            bytes_left_next = '0;
            crc_next        = seed_reg;
            hcrc_next       = HDR_INIT;
            hbits_next      = {frame_items.indicators[1:0], frame_items.fid,
                               frame_items.payload_words};
        end
        else if (byte_acc)
        begin
            crc_next        = crc_upd;
            bytes_left_next = bytes_left_reg - 8'd1;
        end
        else if (state_reg == F_HCRC)
        begin
            hcrc_next  = hdr_crc_chunk(hcrc_reg, hbits_reg[19:15]);
            hbits_next = {hbits_reg[14:0], 5'd0};
        end
        else if ((state_reg == F_HDR) && !q_full)
        begin
            crc_next = crc_upd;
            if (step_reg == HDR_LAST)
            begin
                in_frame_next   = (words_reg != '0);
                bytes_left_next = {words_reg, 1'b0};
            end
        end
        else if ((state_reg == F_TRL) && !q_full && (step_reg == TRL_LAST))
        begin
            in_frame_next   = 1'b0;
            bytes_left_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            step_reg       <= '0;
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= '0;
            crc_reg        <= '0;
            seed_reg       <= FRAME_CRC_SEED_RST;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
            crc_reg        <= crc_next;
            if (cfg_we)
            begin
                seed_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hcrc_reg  <= hcrc_next;
        hbits_reg <= hbits_next;
        if (start_acc)
        begin
            id_reg    <= frame_items.fid;
            ind_reg   <= frame_items.indicators;
            words_reg <= frame_items.payload_words;
            cyc_reg   <= frame_items.cycle_no;
        end
    end

endmodule

@@ hw/rtl/fbe_queue.sv @@
module fbe_queue #(
    parameter int DEPTH = fbe_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  fbe_pkg::push_t push,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output fbe_pkg::grp_t  head
);
    import fbe_pkg::*;

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    grp_t              slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == FILL_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots[rd_ptr_reg];
    assign do_push   = push.valid && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + FILL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push.grp;
        end
    end

endmodule

@@ hw/rtl/fbe_back.sv @@
module fbe_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  fbe_pkg::grp_t q_head,
    output logic          pop,
    fbe_group_if.source   wire_groups
);
    import fbe_pkg::*;

    logic             valid_reg;
    logic [SYM_W-1:0] bits_reg, bits_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             last_reg;

    // The output register refills whenever it is empty or its beat is taken.
    assign pop = q_valid && (!valid_reg || wire_groups.ready);

    always_comb
    begin
        unique case (q_head.kind)
            K_TSS:
            begin
                bits_next  = SYM_TSS;
                count_next = BITS_TSS;
            end
            K_FES:
            begin
                bits_next  = SYM_FES;
                count_next = BITS_FES;
            end
            default:
            begin
                bits_next  = {2'b00, SYM_BSS, q_head.data};
                count_next = BITS_BYTE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || wire_groups.ready)
        begin
            valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            bits_reg  <= bits_next;
            count_reg <= count_next;
            last_reg  <= q_head.last;
        end
    end

    assign wire_groups.valid       = valid_reg;
    assign wire_groups.symbol_bits = bits_reg;
    assign wire_groups.bit_count   = count_reg;
    assign wire_groups.last        = last_reg;

endmodule

@@ hw/rtl/flexray_frame_bit_encoder_core.sv @@
// FlexRay frame bit encoder.
// frame_items (valid/ready) takes one beat per item: a start beat (func 0) with the
// header fields, or a payload byte beat (func 1). wire_groups (valid/ready) gives one
// beat per group of wire bits, first bit sent in position bit_count-1: TSS+FSS (9 bits),
// BSS-framed bytes (10 bits) and FES plus idle delimiter (12 bits); last marks the
// final beat caused by an input beat. cfg_we/cfg_wdata load the frame CRC seed.
// A payload byte beat's group passes through the queue and then the output register.
// A start beat occupies the front sequencer while it computes the header CRC (five
// bits a cycle) and sends the five header bytes through the shared frame CRC unit; the
// final payload byte adds the CRC trailer. Payload bytes can arrive back to back, one
// per cycle while the queue has room, and the output carries at most one group per cycle.
// Payload bytes outside a frame are accepted and dropped; a start beat abandons any
// open frame. A small queue between sequencer and output register lets the front keep
// accepting while the receiver stalls; once it fills, frame_items.ready drops.
// Reset clears the frame state, empties the queue and restores the seed to 0xFEDCBA.
module flexray_frame_bit_encoder_core #(
    parameter int QUEUE_DEPTH = fbe_pkg::QUEUE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [fbe_pkg::CRC_W-1:0] cfg_wdata,
    fbe_item_if.sink                  frame_items,
    fbe_group_if.source               wire_groups
);
    import fbe_pkg::*;

    push_t push;
    grp_t  q_head;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;

    fbe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .frame_items (frame_items),
        .q_full      (q_full),
        .push        (push)
    );

    fbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    fbe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .pop         (q_pop),
        .wire_groups (wire_groups)
    );

endmodule

@@ hw/rtl/fbe_checker.sv @@
module fbe_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      valid,
    input logic                      ready,
    input logic [fbe_pkg::SYM_W-1:0] symbol_bits,
    input logic [fbe_pkg::CNT_W-1:0] bit_count,
    input logic                      last
);
    import fbe_pkg::*;

    // A stalled beat stays on the port unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(symbol_bits) && $stable(bit_count)
                            && $stable(last))
        else $error("wire group changed while stalled");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (bit_count == BITS_TSS) || (bit_count == BITS_BYTE)
                  || (bit_count == BITS_FES))
        else $error("bad bit count");

    // A frame start is always followed by its header, so it never ends an item.
    a_tss: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (bit_count == BITS_TSS) |-> (symbol_bits == SYM_TSS) && !last)
        else $error("bad start sequence group");

    a_fes: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (bit_count == BITS_FES) |-> (symbol_bits == SYM_FES) && last)
        else $error("bad end sequence group");

    a_bss: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (bit_count == BITS_BYTE) |-> (symbol_bits[SYM_W-1:8] == {2'b00, SYM_BSS}))
        else $error("byte group without byte start sequence");

endmodule

bind flexray_frame_bit_encoder_core fbe_checker u_fbe_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (wire_groups.valid),
    .ready       (wire_groups.ready),
    .symbol_bits (wire_groups.symbol_bits),
    .bit_count   (wire_groups.bit_count),
    .last        (wire_groups.last)
);
